@@ src/dewf_pkg.sv @@
`default_nettype none
package dewf_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [2:0] KIND_LEADING  = 3'd0;
    localparam logic [2:0] KIND_TRAILING = 3'd1;
    localparam logic [2:0] KIND_STAMP    = 3'd2;
    localparam logic [2:0] KIND_ERROR    = 3'd3;
    localparam logic [2:0] KIND_SPILL    = 3'd4;
    localparam logic [2:0] KIND_EVENT    = 3'd5;

    localparam logic [2:0] REG_SYNC_WORD       = 3'd0;
    localparam logic [2:0] REG_SPILL_END_WORD  = 3'd1;
    localparam logic [2:0] REG_TDC_DEVICE_ID   = 3'd2;
    localparam logic [2:0] REG_MAX_EVENT_WORDS = 3'd3;
    localparam logic [2:0] REG_MAX_BLOCK_WORDS = 3'd4;
    localparam logic [2:0] REG_MAX_EVENTS      = 3'd5;

    localparam logic [30:0] MAX_EVENT_WORDS_RESET = 31'd100000;
    localparam logic [21:0] MAX_BLOCK_WORDS_RESET = 22'(2000000);

    typedef struct packed {
        logic [31:0] sync_word;
        logic [31:0] spill_end_word;
        logic [7:0]  tdc_device_id;
        logic [30:0] max_event_words;
        logic [21:0] max_block_words;
        logic [31:0] max_events;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] serial;
        logic [31:0] event_id;
        logic [6:0]  channel;
        logic [20:0] hit_time;
        logic [31:0] seconds;
        logic [27:0] nanoseconds;
        logic [3:0]  tai_flags;
        logic [14:0] error_code;
        logic [3:0]  chip_id;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [1:0] n;
        rec_t       r0;
        rec_t       r1;
    } push_t;

endpackage
`default_nettype wire

@@ src/dewf_in_if.sv @@
`default_nettype none
interface dewf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

@@ src/dewf_out_if.sv @@
`default_nettype none
interface dewf_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] serial;
    logic [31:0] event_id;
    logic [6:0]  channel;
    logic [20:0] hit_time;
    logic [31:0] seconds;
    logic [27:0] nanoseconds;
    logic [3:0]  tai_flags;
    logic [14:0] error_code;
    logic [3:0]  chip_id;
    logic        last;

    modport source (output valid, output kind, output serial, output event_id,
                    output channel, output hit_time, output seconds,
                    output nanoseconds, output tai_flags, output error_code,
                    output chip_id, output last, input ready);
    modport sink (input valid, input kind, input serial, input event_id,
                  input channel, input hit_time, input seconds,
                  input nanoseconds, input tai_flags, input error_code,
                  input chip_id, input last, output ready);
endinterface
`default_nettype wire

@@ src/dewf_parser.sv @@
`default_nettype none
module dewf_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [31:0]    word,
    input  wire dewf_pkg::cfg_t cfg,
    output dewf_pkg::push_t     push
);
    import dewf_pkg::*;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_LEN,
        ST_ID,
        ST_SERIAL,
        ST_BHDR,
        ST_BODY,
        ST_TDCHDR,
        ST_TDCHITS,
        ST_SKIPEV,
        ST_DROP
    } mode_t;

    localparam logic [3:0] TYPE_LEADING  = 4'd4;
    localparam logic [3:0] TYPE_TRAILING = 4'd5;
    localparam logic [3:0] TYPE_ERROR    = 4'd6;
    localparam logic [3:0] TYPE_TRAILER  = 4'd7;

    mode_t       mode_reg, mode_next;
    logic [30:0] ewl_reg, ewl_next, ewl_dec, words;
    logic [21:0] bwl_reg, bwl_next, bwl_dec, payload;
    logic [1:0]  hidx_reg, hidx_next;
    logic [31:0] evid_reg, evid_next;
    logic [31:0] serial_reg, serial_next;
    logic [31:0] secs_reg, secs_next;
    logic [31:0] events_reg, events_next;
    logic        closed_reg, closed_next;
    logic        halted, go;
    logic        p_valid, e_valid;
    rec_t        p_rec, e_rec;

    assign halted = (cfg.max_events != 32'd0) && (events_reg == cfg.max_events);
    assign go     = accept && !halted;

    always_comb
    begin
        mode_next   = mode_reg;
        ewl_next    = ewl_reg;
        bwl_next    = bwl_reg;
        hidx_next   = hidx_reg;
        evid_next   = evid_reg;
        serial_next = serial_reg;
        secs_next   = secs_reg;
        events_next = events_reg;
        closed_next = closed_reg;
        p_valid     = 1'b0;
        e_valid     = 1'b0;
        p_rec       = '0;
        e_rec       = '0;
        words       = {1'b0, word[31:2]} + 31'd1;
        ewl_dec     = ewl_reg - 31'd1;
        bwl_dec     = bwl_reg - 22'd1;
        payload     = word[23:2];
        if (go)
        begin
            if (mode_reg == ST_HUNT)
            begin
                if (word == cfg.spill_end_word)
                begin
                    p_valid    = 1'b1;
                    p_rec.kind = KIND_SPILL;
                end
                if (word == cfg.sync_word)
                begin
                    mode_next = ST_LEN;
                end
            end
            else if (mode_reg == ST_LEN)
            begin
                ewl_next  = words;
                mode_next = (words >= cfg.max_event_words) ? ST_SKIPEV : ST_ID;
            end
            else
            begin
                ewl_next = ewl_dec;
                unique case (mode_reg) inside
                    ST_ID:
                    begin
                        evid_next = word;
                        mode_next = (word == 32'd0) ? ST_SKIPEV : ST_SERIAL;
                    end
                    ST_SERIAL:
                    begin
                        serial_next = word;
                        mode_next   = ST_BHDR;
                    end
                    ST_BHDR:
                    begin
                        if (payload > cfg.max_block_words)
                        begin
                            mode_next = ST_DROP;
                        end
                        else
                        begin
                            bwl_next    = payload;
                            closed_next = 1'b0;
                            hidx_next   = 2'd0;
                            if (payload == 22'd0)
                                mode_next = ST_SERIAL;
                            else if (word[31:24] == cfg.tdc_device_id)
                                mode_next = ST_TDCHDR;
                            else
                                mode_next = ST_BODY;
                        end
                    end
                    ST_BODY, ST_TDCHDR, ST_TDCHITS:
                    begin
                        bwl_next = bwl_dec;
                        if (mode_reg == ST_TDCHDR)
                        begin
                            if (hidx_reg == 2'd1)
                            begin
                                secs_next = word;
                            end
                            else if (hidx_reg == 2'd2)
                            begin
                                p_valid           = 1'b1;
                                p_rec.kind        = KIND_STAMP;
                                p_rec.serial      = serial_reg;
                                p_rec.event_id    = evid_reg;
                                p_rec.seconds     = secs_reg;
                                p_rec.nanoseconds = word[27:0];
                                p_rec.tai_flags   = word[31:28];
                            end
                            if (hidx_reg == 2'd3)
                                mode_next = ST_TDCHITS;
                            else
                                hidx_next = hidx_reg + 2'd1;
                        end
                        else if (mode_reg == ST_TDCHITS && !closed_reg)
                        begin
                            if (word[31:28] == TYPE_TRAILER)
                            begin
                                closed_next = 1'b1;
                            end
                            else if (word[31:28] == TYPE_ERROR)
                            begin
                                p_valid          = 1'b1;
                                p_rec.kind       = KIND_ERROR;
                                p_rec.serial     = serial_reg;
                                p_rec.event_id   = evid_reg;
                                p_rec.error_code = word[14:0];
                                p_rec.chip_id    = word[27:24];
                                closed_next      = 1'b1;
                            end
                            else if (word[31:28] == TYPE_LEADING ||
                                     word[31:28] == TYPE_TRAILING)
                            begin
                                p_valid        = 1'b1;
                                p_rec.kind     = (word[31:28] == TYPE_LEADING) ?
                                                 KIND_LEADING : KIND_TRAILING;
                                p_rec.serial   = serial_reg;
                                p_rec.event_id = evid_reg;
                                p_rec.channel  = word[27:21];
                                p_rec.hit_time = word[20:0];
                            end
                        end
                        if (bwl_dec == 22'd0)
                            mode_next = ST_SERIAL;
                    end
                    default:
                    begin
                    end
                endcase
                if (ewl_dec == 31'd0)
                begin
                    if (mode_next != ST_SKIPEV)
                    begin
                        e_valid        = 1'b1;
                        e_rec.kind     = KIND_EVENT;
                        e_rec.event_id = evid_next;
                        e_rec.last     = 1'b1;
                        events_next    = events_reg + 32'd1;
                    end
                    mode_next = ST_HUNT;
                end
            end
        end
    end

    always_comb
    begin
        push = '0;
        if (p_valid && e_valid)
        begin
            push.n  = 2'd2;
            push.r0 = p_rec;
            push.r1 = e_rec;
        end
        else if (e_valid)
        begin
            push.n  = 2'd1;
            push.r0 = e_rec;
        end
        else if (p_valid)
        begin
            push.n       = 2'd1;
            push.r0      = p_rec;
            push.r0.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ST_HUNT;
            ewl_reg    <= '0;
            bwl_reg    <= '0;
            hidx_reg   <= '0;
            evid_reg   <= '0;
            serial_reg <= '0;
            secs_reg   <= '0;
            events_reg <= '0;
            closed_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            ewl_reg    <= ewl_next;
            bwl_reg    <= bwl_next;
            hidx_reg   <= hidx_next;
            evid_reg   <= evid_next;
            serial_reg <= serial_next;
            secs_reg   <= secs_next;
            events_reg <= events_next;
            closed_reg <= closed_next;
        end
    end
endmodule
`default_nettype wire

@@ src/dewf_outq.sv @@
`default_nettype none
module dewf_outq #(
    parameter int unsigned DEPTH = dewf_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dewf_pkg::push_t push,
    input  wire logic            pop,
    output logic                 valid,
    output logic                 space,
    output dewf_pkg::rec_t       head
);
    import dewf_pkg::*;

    localparam int unsigned IDXW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNTW = $clog2(DEPTH + 1);

    rec_t            mem [DEPTH];
    logic [IDXW-1:0] wr_reg, wr_next, wr1, wr2, rd_reg, rd_next;
    logic [CNTW-1:0] count_reg, count_next;

    function automatic logic [IDXW-1:0] inc(input logic [IDXW-1:0] p);
        logic [IDXW-1:0] r;
        r = (p == IDXW'(DEPTH - 1)) ? '0 : p + IDXW'(1);
        return r;
    endfunction

    assign wr1   = inc(wr_reg);
    assign wr2   = inc(wr1);
    assign valid = (count_reg != '0);
    assign space = (count_reg <= CNTW'(DEPTH - 2));
    assign head  = mem[rd_reg];

    always_comb
    begin
        case (push.n)
            2'd1:    wr_next = wr1;
            2'd2:    wr_next = wr2;
            default: wr_next = wr_reg;
        endcase
        rd_next    = pop ? inc(rd_reg) : rd_reg;
        count_next = count_reg + CNTW'(push.n) - CNTW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wr_reg] <= push.r0;
        if (push.n == 2'd2)
            mem[wr1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end
endmodule
`default_nettype wire

@@ src/daq_event_word_deframer.sv @@
// a result is registered into the result queue and offered from the queue head
// throughput: one item per cycle while ready is high; an item may give two results
// input ready stays high while the result queue has room for two more results
// reset: parse state, counters and queue cleared, registers to their defaults
`default_nettype none
module daq_event_word_deframer #(
    parameter int unsigned QUEUE_DEPTH = dewf_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dewf_in_if.sink          in_ch,
    dewf_out_if.source       out_ch,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import dewf_pkg::*;

    cfg_t  cfg_reg;
    push_t push;
    rec_t  head;
    logic  space, q_valid, accept, pop;

    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;
    assign pop         = q_valid && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_word       <= '0;
            cfg_reg.spill_end_word  <= '0;
            cfg_reg.tdc_device_id   <= '0;
            cfg_reg.max_event_words <= MAX_EVENT_WORDS_RESET;
            cfg_reg.max_block_words <= MAX_BLOCK_WORDS_RESET;
            cfg_reg.max_events      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYNC_WORD:       cfg_reg.sync_word       <= cfg_data;
                REG_SPILL_END_WORD:  cfg_reg.spill_end_word  <= cfg_data;
                REG_TDC_DEVICE_ID:   cfg_reg.tdc_device_id   <= cfg_data[7:0];
                REG_MAX_EVENT_WORDS: cfg_reg.max_event_words <= cfg_data[30:0];
                REG_MAX_BLOCK_WORDS: cfg_reg.max_block_words <= cfg_data[21:0];
                REG_MAX_EVENTS:      cfg_reg.max_events      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    dewf_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (in_ch.word),
        .cfg    (cfg_reg),
        .push   (push)
    );

    dewf_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .valid (q_valid),
        .space (space),
        .head  (head)
    );

    assign out_ch.valid       = q_valid;
    assign out_ch.kind        = head.kind;
    assign out_ch.serial      = head.serial;
    assign out_ch.event_id    = head.event_id;
    assign out_ch.channel     = head.channel;
    assign out_ch.hit_time    = head.hit_time;
    assign out_ch.seconds     = head.seconds;
    assign out_ch.nanoseconds = head.nanoseconds;
    assign out_ch.tai_flags   = head.tai_flags;
    assign out_ch.error_code  = head.error_code;
    assign out_ch.chip_id     = head.chip_id;
    assign out_ch.last        = head.last;
endmodule
`default_nettype wire

@@ src/dewf_checker.sv @@
`default_nettype none
module dewf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  kind,
    input wire logic [31:0] serial,
    input wire logic [31:0] event_id,
    input wire logic [6:0]  channel,
    input wire logic [20:0] hit_time,
    input wire logic        last
);
    import dewf_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_event_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EVENT |-> last && serial == 32'd0)
        else $error("event end not last or carries serial");

    a_spill_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SPILL |-> last && serial == 32'd0 && event_id == 32'd0)
        else $error("spill end item malformed");

    a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_LEADING && kind != KIND_TRAILING
        |-> channel == 7'd0 && hit_time == 21'd0)
        else $error("hit fields set on non-hit item");
endmodule

bind daq_event_word_deframer dewf_checker u_dewf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .kind      (out_ch.kind),
    .serial    (out_ch.serial),
    .event_id  (out_ch.event_id),
    .channel   (out_ch.channel),
    .hit_time  (out_ch.hit_time),
    .last      (out_ch.last)
);
`default_nettype wire
